// ===== rtl/linear_adsr_voice_gain_unit_defines.svh =====
`ifndef LINEAR_ADSR_VOICE_GAIN_UNIT_DEFINES_SVH
`define LINEAR_ADSR_VOICE_GAIN_UNIT_DEFINES_SVH

// same-cycle implication on clk, switched off while rst is high
`define LAVG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, switched off while rst is high
`define LAVG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lavg_pkg.sv =====
package lavg_pkg;

  // field and datapath widths
  localparam int SAMPLE_W   = 24;
  localparam int ENV_FRAC   = 23;
  localparam int STEP_FRAC  = 15;
  localparam int LEVEL_W    = ENV_FRAC + 1;
  localparam int ACC_W      = LEVEL_W + STEP_FRAC;
  localparam int STEP_W     = ACC_W + 1;
  localparam int SUM_W      = ACC_W + 2;
  localparam int LEN_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int VEL_W      = 16;
  localparam int REQ_W      = 2;
  localparam int PHASE_W    = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // shared multiplier and divider sizing
  localparam int MUL_A_W   = 28;
  localparam int MUL_B_W   = 24;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_STEPS = ACC_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(1) << ENV_FRAC;
  localparam logic [ACC_W-1:0]   ACC_TOP    = ACC_W'(1) << (ACC_W - 1);

  // reset values of the settings registers
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST = FULL_LEVEL;
  localparam logic [GAIN_W-1:0]  GAIN_RST    = GAIN_W'(4096);

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK = 2'd0,
    REQ_ON   = 2'd1,
    REQ_OFF  = 2'd2
  } req_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_RELEASE = 3'd2,
    CFG_SUSTAIN = 3'd3,
    CFG_GAIN    = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_DIV,
    S_STEP,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_ROUND,
    S_FINISH
  } seq_t;

endpackage

// ===== rtl/lavg_if.sv =====
// request channel: one voice command per transfer
interface lavg_req_if;
  import lavg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [VEL_W-1:0]           velocity_in;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, req_type, velocity_in, sample_in, input ready);
  modport sink (input valid, req_type, velocity_in, sample_in, output ready);
endinterface

// result channel: one result per request
interface lavg_res_if;
  import lavg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [LEVEL_W-1:0]         envelope_level;
  logic [PHASE_W-1:0]         phase;
  logic                       stealable;

  modport source (output valid, sample_out, envelope_level, phase, stealable, input ready);
  modport sink (input valid, sample_out, envelope_level, phase, stealable, output ready);
endinterface

// ===== rtl/linear_adsr_voice_gain_unit.sv =====
// one request at a time; ready only while the sequencer is idle
// plain tick: exec, mul1, mul2, mul3 and round, then finish registers the result
// note off or tick while idle, or an unknown request: exec, then finish
// note on always starts a phase: start state, then at nonzero length the bit-serial 39-step
// divider, then step; gain path uses one shared 28x24 multiplier three times per active tick
// rst (synchronous, active high) clears the envelope to idle and loads the default settings
`include "linear_adsr_voice_gain_unit_defines.svh"

module linear_adsr_voice_gain_unit (
  input  logic                              clk,
  input  logic                              rst,
  lavg_req_if.sink                          req,
  lavg_res_if.source                        res,
  input  logic                              cfg_we,
  input  logic [lavg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lavg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lavg_pkg::*;

  // settings registers
  logic [LEN_W-1:0]   attack_samples;
  logic [LEN_W-1:0]   decay_samples;
  logic [LEN_W-1:0]   release_samples;
  logic [LEVEL_W-1:0] sustain_level;
  logic [GAIN_W-1:0]  base_gain;

  // sequencer and envelope state
  seq_t                state, state_next;
  phase_t              phase_reg, phase_reg_next;
  logic [ACC_W-1:0]    acc, acc_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [LEVEL_W-1:0]  target_level, target_level_next;
  logic [VEL_W-1:0]    velocity_reg, velocity_reg_next;

  // latched request and working registers
  logic [REQ_W-1:0]           req_type_r, req_type_r_next;
  logic [VEL_W-1:0]           velocity_in_r, velocity_in_r_next;
  logic [SAMPLE_W-1:0]        sample_in_r, sample_in_r_next;
  logic [LEN_W-1:0]           len_r, len_r_next;
  logic                       tick_r, tick_r_next;
  logic [ACC_W-1:0]           quo, quo_next;
  logic [LEN_W:0]             rem, rem_next;
  logic [CNT_W-1:0]           div_cnt, div_cnt_next;
  logic                       diff_neg, diff_neg_next;
  logic                       diff_nz, diff_nz_next;
  logic [PROD_W-1:0]          prod, prod_next;
  logic [SAMPLE_W-1:0]        sout, sout_next;

  // result register
  logic                 out_valid, out_valid_next;
  logic [SAMPLE_W-1:0]  out_sample, out_sample_next;
  logic [LEVEL_W-1:0]   out_level, out_level_next;
  logic [PHASE_W-1:0]   out_phase, out_phase_next;
  logic                 out_steal, out_steal_next;

  // combinational helpers
  logic signed [SUM_W-1:0]  acc_s, step_s, sum, top_s, tgt_s;
  logic [ACC_W-1:0]         tgt_acc;
  logic signed [STEP_W-1:0] diff;
  logic [STEP_W-1:0]        diff_mag;
  logic [LEN_W:0]           rem_sh;
  logic                     rem_ge;
  logic [ACC_W-1:0]         q_mag;
  logic [STEP_W-1:0]        q_ext;
  logic [LEVEL_W-1:0]       sus_cl;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic                     s_neg;
  logic [SAMPLE_W-1:0]      s_mag;
  logic                     rnd_inc;
  logic [PROD_W-ENV_FRAC:0] r_raw;
  logic [SAMPLE_W-1:0]      r_lim;
  logic [SAMPLE_W-1:0]      r_sat;

  assign req.ready          = (state == S_IDLE);
  assign res.valid          = out_valid;
  assign res.sample_out     = out_sample;
  assign res.envelope_level = out_level;
  assign res.phase          = out_phase;
  assign res.stealable      = out_steal;

  // settings write port
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples  <= '0;
      decay_samples   <= '0;
      release_samples <= '0;
      sustain_level   <= SUSTAIN_RST;
      base_gain       <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK:  attack_samples  <= cfg_data[LEN_W-1:0];
        CFG_DECAY:   decay_samples   <= cfg_data[LEN_W-1:0];
        CFG_RELEASE: release_samples <= cfg_data[LEN_W-1:0];
        CFG_SUSTAIN: sustain_level   <= cfg_data[LEVEL_W-1:0];
        CFG_GAIN:    base_gain       <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // envelope accumulator step and phase-end levels
  assign acc_s   = $signed({2'b00, acc});
  assign step_s  = $signed({step[STEP_W-1], step});
  assign sum     = acc_s + step_s;
  assign top_s   = $signed({2'b00, ACC_TOP});
  assign tgt_acc = {target_level, {STEP_FRAC{1'b0}}};
  assign tgt_s   = $signed({2'b00, tgt_acc});
  assign sus_cl  = (sustain_level > FULL_LEVEL) ? FULL_LEVEL : sustain_level;

  // distance to target, as sign and magnitude for the divider
  assign diff     = $signed({1'b0, tgt_acc}) - $signed({1'b0, acc});
  assign diff_mag = diff[STEP_W-1] ? (~diff + STEP_W'(1)) : diff;

  // restoring divider step
  assign rem_sh = {rem[LEN_W-1:0], quo[ACC_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, len_r});

  // step magnitude, never zero while the target is still away
  assign q_mag = ((quo == '0) && diff_nz) ? ACC_W'(1) : quo;
  assign q_ext = {1'b0, q_mag};

  // shared multiplier
  assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // sample magnitude and output rounding
  assign s_neg   = sample_in_r[SAMPLE_W-1];
  assign s_mag   = s_neg ? (~sample_in_r + SAMPLE_W'(1)) : sample_in_r;
  assign rnd_inc = s_neg ? (prod[ENV_FRAC-1] && (|prod[ENV_FRAC-2:0]))
                         : prod[ENV_FRAC-1];
  assign r_raw   = {1'b0, prod[PROD_W-1:ENV_FRAC]} + (PROD_W-ENV_FRAC+1)'(rnd_inc);
  assign r_lim   = s_neg ? (SAMPLE_W'(1) << (SAMPLE_W - 1))
                         : ((SAMPLE_W'(1) << (SAMPLE_W - 1)) - SAMPLE_W'(1));
  assign r_sat   = (r_raw > (PROD_W-ENV_FRAC+1)'(r_lim)) ? r_lim : r_raw[SAMPLE_W-1:0];

  // sequencer
  always_comb begin
    state_next         = state;
    phase_reg_next     = phase_reg;
    acc_next           = acc;
    step_next          = step;
    target_level_next  = target_level;
    velocity_reg_next  = velocity_reg;
    req_type_r_next    = req_type_r;
    velocity_in_r_next = velocity_in_r;
    sample_in_r_next   = sample_in_r;
    len_r_next         = len_r;
    tick_r_next        = tick_r;
    quo_next           = quo;
    rem_next           = rem;
    div_cnt_next       = div_cnt;
    diff_neg_next      = diff_neg;
    diff_nz_next       = diff_nz;
    prod_next          = prod;
    sout_next          = sout;
    out_valid_next     = out_valid;
    out_sample_next    = out_sample;
    out_level_next     = out_level;
    out_phase_next     = out_phase;
    out_steal_next     = out_steal;
    mul_a              = '0;
    mul_b              = '0;

    if (res.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          req_type_r_next    = req.req_type;
          velocity_in_r_next = req.velocity_in;
          sample_in_r_next   = req.sample_in;
          state_next         = S_EXEC;
        end
      end

      S_EXEC: begin
        sout_next   = '0;
        tick_r_next = 1'b0;
        if (req_type_r == REQ_ON) begin
          velocity_reg_next = velocity_in_r;
          acc_next          = '0;
          phase_reg_next    = PH_ATTACK;
          target_level_next = FULL_LEVEL;
          len_r_next        = attack_samples;
          state_next        = S_START;
        end else if (req_type_r == REQ_OFF) begin
          if (phase_reg != PH_IDLE) begin
            phase_reg_next    = PH_RELEASE;
            target_level_next = '0;
            len_r_next        = release_samples;
            state_next        = S_START;
          end else begin
            state_next = S_FINISH;
          end
        end else if ((req_type_r == REQ_TICK) && (phase_reg != PH_IDLE)) begin
          tick_r_next = 1'b1;
          state_next  = S_MUL1;
          case (phase_reg)
            PH_ATTACK: begin
              if (sum >= top_s) begin
                acc_next          = ACC_TOP;
                phase_reg_next    = PH_DECAY;
                target_level_next = sus_cl;
                len_r_next        = decay_samples;
                state_next        = S_START;
              end else begin
                acc_next = sum[ACC_W-1:0];
              end
            end
            PH_DECAY: begin
              if (sum <= tgt_s) begin
                acc_next       = tgt_acc;
                phase_reg_next = PH_SUSTAIN;
                step_next      = '0;
              end else begin
                acc_next = sum[ACC_W-1:0];
              end
            end
            PH_RELEASE: begin
              if (sum[SUM_W-1] || (sum == '0)) begin
                acc_next       = '0;
                phase_reg_next = PH_IDLE;
                step_next      = '0;
              end else begin
                acc_next = sum[ACC_W-1:0];
              end
            end
            default: ;
          endcase
        end else begin
          state_next = S_FINISH;
        end
      end

      // phase start: jump on zero length, else divide the distance
      S_START: begin
        if (len_r == '0) begin
          acc_next   = tgt_acc;
          step_next  = '0;
          state_next = tick_r ? S_MUL1 : S_FINISH;
        end else begin
          diff_neg_next = diff[STEP_W-1];
          diff_nz_next  = (diff != '0);
          quo_next      = diff_mag[ACC_W-1:0];
          rem_next      = '0;
          div_cnt_next  = '0;
          state_next    = S_DIV;
        end
      end

      // one quotient bit per cycle
      S_DIV: begin
        rem_next     = rem_ge ? (rem_sh - {1'b0, len_r}) : rem_sh;
        quo_next     = {quo[ACC_W-2:0], rem_ge};
        div_cnt_next = div_cnt + CNT_W'(1);
        if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_STEP;
        end
      end

      S_STEP: begin
        step_next  = diff_neg ? (~q_ext + STEP_W'(1)) : q_ext;
        state_next = tick_r ? S_MUL1 : S_FINISH;
      end

      // level times velocity
      S_MUL1: begin
        mul_a      = MUL_A_W'(acc[ACC_W-1:STEP_FRAC]);
        mul_b      = MUL_B_W'(velocity_reg);
        prod_next  = mul_p;
        state_next = S_MUL2;
      end

      // times base gain
      S_MUL2: begin
        mul_a      = MUL_A_W'(prod[VEL_W +: LEVEL_W]);
        mul_b      = MUL_B_W'(base_gain);
        prod_next  = mul_p;
        state_next = S_MUL3;
      end

      // gain times sample magnitude
      S_MUL3: begin
        mul_a      = prod[GAIN_FRAC +: MUL_A_W];
        mul_b      = MUL_B_W'(s_mag);
        prod_next  = mul_p;
        state_next = S_ROUND;
      end

      S_ROUND: begin
        sout_next  = s_neg ? (~r_sat + SAMPLE_W'(1)) : r_sat;
        state_next = S_FINISH;
      end

      // hand the result over once the result register is free
      S_FINISH: begin
        if (!out_valid || res.ready) begin
          out_valid_next  = 1'b1;
          out_sample_next = sout;
          out_level_next  = acc[ACC_W-1:STEP_FRAC];
          out_phase_next  = phase_reg;
          out_steal_next  = (phase_reg == PH_RELEASE);
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control and envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase_reg    <= PH_IDLE;
      acc          <= '0;
      step         <= '0;
      target_level <= '0;
      velocity_reg <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      phase_reg    <= phase_reg_next;
      acc          <= acc_next;
      step         <= step_next;
      target_level <= target_level_next;
      velocity_reg <= velocity_reg_next;
      out_valid    <= out_valid_next;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    req_type_r    <= req_type_r_next;
    velocity_in_r <= velocity_in_r_next;
    sample_in_r   <= sample_in_r_next;
    len_r         <= len_r_next;
    tick_r        <= tick_r_next;
    quo           <= quo_next;
    rem           <= rem_next;
    div_cnt       <= div_cnt_next;
    diff_neg      <= diff_neg_next;
    diff_nz       <= diff_nz_next;
    prod          <= prod_next;
    sout          <= sout_next;
    out_sample    <= out_sample_next;
    out_level     <= out_level_next;
    out_phase     <= out_phase_next;
    out_steal     <= out_steal_next;
  end

  // checks
  `LAVG_ASSERT_NEXT(a_busy_after_transfer, req.valid && req.ready, !req.ready,
                    "request taken while previous one still in work")
  `LAVG_ASSERT_NOW(a_level_in_range, 1'b1, acc <= ACC_TOP,
                   "envelope accumulator above full scale")
  `LAVG_ASSERT_NOW(a_flat_phase_no_step, phase_reg == PH_IDLE || phase_reg == PH_SUSTAIN,
                   step == '0, "nonzero step while idle or sustaining")
  `LAVG_ASSERT_NOW(a_result_from_finish, $rose(res.valid), $past(state) == S_FINISH,
                   "result raised outside the finish step")

endmodule
